/* design/gda_pkg.sv */
// Shared types, constants and calendar helpers for the Gregorian date unit.
// No dependencies; compile first.
package gda_pkg;

    localparam int OP_W     = 3;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMT_W    = 16;
    localparam int COUNT_W  = 23;
    localparam int STATUS_W = 2;
    localparam int SER_W    = 22;   // day serial, 0 = 0001-01-01
    localparam int TY_W     = 17;   // target year before range check
    localparam int QY_W     = 10;   // year / 100
    localparam int Q12_W    = 13;   // month total / 12

    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd9999;
    localparam logic [SER_W-1:0]  SERIAL_MAX = 22'd3652058;
    localparam logic [SER_W-1:0]  DAYS_400   = 22'd146097;
    localparam logic [SER_W-1:0]  DAYS_100   = 22'd36524;
    localparam logic [SER_W-1:0]  DAYS_4     = 22'd1461;
    localparam logic [SER_W-1:0]  DAYS_1     = 22'd365;

    // floor(x/100) = (x * 5243) >> 19 for x < 2^14
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    // floor(x/3) = (x * 21846) >> 16 for x < 2^15
    localparam logic [14:0] RECIP_3         = 15'd21846;
    localparam int          RECIP_3_SHIFT   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_NEXT, OP_PREV, OP_ADD_YEARS, OP_ADD_MONTHS,
        OP_ADD_DAYS, OP_BETWEEN, OP_COMPARE, OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK, ST_BAD_DATE, ST_RANGE
    } status_t;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_CAPTURE, CMD_LD_FIRST, CMD_LD_SECOND, CMD_LD_YEARS,
        CMD_MONTH_DIV, CMD_LD_MONTHS, CMD_SER_A, CMD_SER_B, CMD_SER_C,
        CMD_SAVE_FIRST, CMD_TARGET, CMD_CV_INIT, CMD_CV_400, CMD_CV_100,
        CMD_CV_4, CMD_CV_1, CMD_CV_MONTH, CMD_RES_ZERO, CMD_RES_BAD,
        CMD_RES_RANGE, CMD_RES_DIFF, CMD_RES_CMP, CMD_RES_DATE
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_SER_A, S_SER_B, S_SER_C, S_CHECK, S_LOAD2,
        S_TARGET, S_LOAD_M, S_CONV_CHK, S_CV_400, S_CV_100, S_CV_4,
        S_CV_1, S_CV_MONTH, S_RESULT, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST, PH_SECOND, PH_TARGET
    } phase_t;

    typedef struct packed {
        cmd_t cmd;
    } gda_ctl_t;

    typedef struct packed {
        op_t  op;
        logic date_ok;
        logic year_ok;
        logic first_zero;
        logic ser_over;
        logic cv_more;
    } gda_stat_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:    d = leap ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

/* design/gda_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on gda_pkg.
interface gda_req_if import gda_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [YEAR_W-1:0]    first_year;
    logic [MONTH_W-1:0]   first_month;
    logic [DAY_W-1:0]     first_day;
    logic [AMT_W-1:0]     amount;
    logic [YEAR_W-1:0]    second_year;
    logic [MONTH_W-1:0]   second_month;
    logic [DAY_W-1:0]     second_day;

    modport source (output valid, operation, first_year, first_month, first_day,
                    amount, second_year, second_month, second_day, input ready);
    modport sink   (input valid, operation, first_year, first_month, first_day,
                    amount, second_year, second_month, second_day, output ready);
endinterface

interface gda_rsp_if import gda_pkg::*;
    ;
    logic                       valid;
    logic                       ready;
    logic [YEAR_W-1:0]          result_year;
    logic [MONTH_W-1:0]         result_month;
    logic [DAY_W-1:0]           result_day;
    logic signed [COUNT_W-1:0]  day_count;
    logic                       is_less;
    logic                       is_equal;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, result_year, result_month, result_day, day_count,
                    is_less, is_equal, status, input ready);
    modport sink   (input valid, result_year, result_month, result_day, day_count,
                    is_less, is_equal, status, output ready);
endinterface

/* design/gda_datapath.sv */
// Datapath: operand capture, date-to-serial, serial-to-date and result registers.
// Depends on gda_pkg; driven by gda_ctrl commands.
module gda_datapath import gda_pkg::*;
(
    input  logic                       clk,
    input  gda_ctl_t                   ctl,
    output gda_stat_t                  stat,
    input  logic [OP_W-1:0]            operation,
    input  logic [YEAR_W-1:0]          first_year,
    input  logic [MONTH_W-1:0]         first_month,
    input  logic [DAY_W-1:0]           first_day,
    input  logic [AMT_W-1:0]           amount,
    input  logic [YEAR_W-1:0]          second_year,
    input  logic [MONTH_W-1:0]         second_month,
    input  logic [DAY_W-1:0]           second_day,
    output logic [YEAR_W-1:0]          result_year,
    output logic [MONTH_W-1:0]         result_month,
    output logic [DAY_W-1:0]           result_day,
    output logic signed [COUNT_W-1:0] day_count,
    output logic                       is_less,
    output logic                       is_equal,
    output logic [STATUS_W-1:0]        status
);

    // captured item
    op_t                op_reg;
    logic [YEAR_W-1:0]  y1_reg, y2_reg;
    logic [MONTH_W-1:0] m1_reg, m2_reg;
    logic [DAY_W-1:0]   d1_reg, d2_reg;
    logic [AMT_W-1:0]   amt_reg;

    // serial unit
    logic [TY_W-1:0]    opd_y_reg;
    logic [MONTH_W-1:0] opd_m_reg;
    logic [DAY_W-1:0]   opd_d_reg;
    logic [QY_W-1:0]    qy_reg;
    logic               leap_reg;
    logic               year_ok_reg;
    logic               date_ok_reg;
    logic [SER_W-1:0]   base_reg;
    logic [SER_W-1:0]   ser_reg;
    logic [SER_W-1:0]   s1_reg;
    logic [TY_W-1:0]    mt_reg;
    logic [Q12_W-1:0]   q12_reg;

    // conversion back to a date
    logic [SER_W-1:0]   r_reg;
    logic [YEAR_W-1:0]  yacc_reg;
    logic [1:0]         n100_reg;
    logic [4:0]         n4_reg;
    logic [1:0]         n1_reg;
    logic [MONTH_W-1:0] k_reg;

    // combinational helpers
    logic [29:0]        prod_a;
    logic [TY_W-1:0]    qy_x100;
    logic               div100, div400, leap_b;
    logic [YEAR_W-1:0]  py;
    logic [QY_W-1:0]    p100, p400;
    logic [SER_W-1:0]   base_b;
    logic [DAY_W-1:0]   mlen_c;
    logic               month_ok_c;
    logic [SER_W-1:0]   ser_c;
    logic [TY_W-1:0]    mtotal;
    logic [29:0]        prod_m;
    logic [TY_W-1:0]    q12_x12;
    logic [TY_W-1:0]    mrem;
    logic               leap_cv;
    logic [DAY_W-1:0]   mlen_cv;
    logic               cv_more;

    always_comb
    begin
        prod_a     = {13'b0, opd_y_reg} * {17'b0, RECIP_100};
        qy_x100    = {7'b0, qy_reg} * 17'd100;
        div100     = (qy_x100 == opd_y_reg);
        div400     = div100 && (qy_reg[1:0] == 2'b00);
        leap_b     = ((opd_y_reg[1:0] == 2'b00) && !div100) || div400;
        py         = opd_y_reg[YEAR_W-1:0] - 14'd1;
        p100       = qy_reg - {9'b0, div100};
        p400       = {2'b0, qy_reg[QY_W-1:2]} - {9'b0, div400};
        base_b     = {8'b0, py} * 22'd365 + {10'b0, py[YEAR_W-1:2]}
                     - {12'b0, p100} + {12'b0, p400};
        mlen_c     = month_days(opd_m_reg, leap_reg);
        month_ok_c = opd_m_reg inside {[4'd1:4'd12]};
        ser_c      = base_reg + {13'b0, cum_days(opd_m_reg)}
                     + {21'b0, (leap_reg && (opd_m_reg > 4'd2))}
                     + {17'b0, opd_d_reg} - 22'd1;
        mtotal     = {13'b0, m1_reg - 4'd1} + {1'b0, amt_reg};
        // month total / 12 as (total / 4) / 3
        prod_m     = {15'b0, mtotal[TY_W-1:2]} * {15'b0, RECIP_3};
        q12_x12    = {4'b0, q12_reg} * 17'd12;
        mrem       = mt_reg - q12_x12;
        leap_cv    = (n1_reg == 2'd3) && ((n4_reg != 5'd24) || (n100_reg == 2'd3));
        mlen_cv    = month_days(k_reg, leap_cv);
        case (ctl.cmd)
            CMD_CV_400:   cv_more = (r_reg >= DAYS_400);
            CMD_CV_100:   cv_more = (n100_reg != 2'd3) && (r_reg >= DAYS_100);
            CMD_CV_4:     cv_more = (r_reg >= DAYS_4);
            CMD_CV_1:     cv_more = (n1_reg != 2'd3) && (r_reg >= DAYS_1);
            CMD_CV_MONTH: cv_more = (k_reg < 4'd12) && (r_reg >= {17'b0, mlen_cv});
            default:      cv_more = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_CAPTURE:
            begin
                op_reg  <= op_t'(operation);
                y1_reg  <= first_year;
                m1_reg  <= first_month;
                d1_reg  <= first_day;
                amt_reg <= amount;
                y2_reg  <= second_year;
                m2_reg  <= second_month;
                d2_reg  <= second_day;
            end
            CMD_LD_FIRST:
            begin
                opd_y_reg <= {3'b0, y1_reg};
                opd_m_reg <= m1_reg;
                opd_d_reg <= d1_reg;
            end
            CMD_LD_SECOND:
            begin
                opd_y_reg <= {3'b0, y2_reg};
                opd_m_reg <= m2_reg;
                opd_d_reg <= d2_reg;
            end
            CMD_LD_YEARS:
            begin
                opd_y_reg <= {3'b0, y1_reg} + {1'b0, amt_reg};
                opd_m_reg <= m1_reg;
                opd_d_reg <= d1_reg;
            end
            CMD_MONTH_DIV:
            begin
                mt_reg  <= mtotal;
                q12_reg <= prod_m[RECIP_3_SHIFT +: Q12_W];
            end
            CMD_LD_MONTHS:
            begin
                opd_y_reg <= {3'b0, y1_reg} + {4'b0, q12_reg};
                opd_m_reg <= mrem[MONTH_W-1:0] + 4'd1;
                opd_d_reg <= d1_reg;
            end
            CMD_SER_A:
                qy_reg <= prod_a[RECIP_100_SHIFT +: QY_W];
            CMD_SER_B:
            begin
                leap_reg    <= leap_b;
                base_reg    <= base_b;
                year_ok_reg <= (opd_y_reg != '0) && (opd_y_reg <= {3'b0, YEAR_MAX});
            end
            CMD_SER_C:
            begin
                ser_reg     <= ser_c;
                date_ok_reg <= year_ok_reg && month_ok_c && (opd_d_reg != '0)
                               && (opd_d_reg <= mlen_c);
            end
            CMD_SAVE_FIRST:
                s1_reg <= ser_reg;
            CMD_TARGET:
            begin
                case (op_reg)
                    OP_NEXT: ser_reg <= s1_reg + 22'd1;
                    OP_PREV: ser_reg <= s1_reg - 22'd1;
                    default: ser_reg <= s1_reg + {6'b0, amt_reg};
                endcase
            end
            CMD_CV_INIT:
            begin
                r_reg    <= ser_reg;
                yacc_reg <= 14'd1;
                n100_reg <= 2'd0;
                n4_reg   <= 5'd0;
                n1_reg   <= 2'd0;
                k_reg    <= 4'd1;
            end
            CMD_CV_400:
                if (cv_more)
                begin
                    r_reg    <= r_reg - DAYS_400;
                    yacc_reg <= yacc_reg + 14'd400;
                end
            CMD_CV_100:
                if (cv_more)
                begin
                    r_reg    <= r_reg - DAYS_100;
                    yacc_reg <= yacc_reg + 14'd100;
                    n100_reg <= n100_reg + 2'd1;
                end
            CMD_CV_4:
                if (cv_more)
                begin
                    r_reg    <= r_reg - DAYS_4;
                    yacc_reg <= yacc_reg + 14'd4;
                    n4_reg   <= n4_reg + 5'd1;
                end
            CMD_CV_1:
                if (cv_more)
                begin
                    r_reg    <= r_reg - DAYS_1;
                    yacc_reg <= yacc_reg + 14'd1;
                    n1_reg   <= n1_reg + 2'd1;
                end
            CMD_CV_MONTH:
                if (cv_more)
                begin
                    r_reg <= r_reg - {17'b0, mlen_cv};
                    k_reg <= k_reg + 4'd1;
                end
            default: ;
        endcase
    end

    // result registers
    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            CMD_RES_ZERO, CMD_RES_BAD, CMD_RES_RANGE, CMD_RES_DIFF,
            CMD_RES_CMP, CMD_RES_DATE:
            begin
                result_year  <= '0;
                result_month <= '0;
                result_day   <= '0;
                day_count    <= '0;
                is_less      <= 1'b0;
                is_equal     <= 1'b0;
                status       <= ST_OK;
                case (ctl.cmd)
                    CMD_RES_BAD:   status <= ST_BAD_DATE;
                    CMD_RES_RANGE: status <= ST_RANGE;
                    CMD_RES_DIFF:  day_count <= {1'b0, ser_reg} - {1'b0, s1_reg};
                    CMD_RES_CMP:
                    begin
                        is_less  <= (s1_reg < ser_reg);
                        is_equal <= (s1_reg == ser_reg);
                    end
                    CMD_RES_DATE:
                    begin
                        result_year  <= yacc_reg;
                        result_month <= k_reg;
                        result_day   <= r_reg[DAY_W-1:0] + 5'd1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.date_ok    = date_ok_reg;
        stat.year_ok    = year_ok_reg;
        stat.first_zero = (s1_reg == '0);
        stat.ser_over   = (ser_reg > SERIAL_MAX);
        stat.cv_more    = cv_more;
    end

endmodule

/* design/gda_ctrl.sv */
// Controller state machine: sequences the datapath through one item.
// Depends on gda_pkg.
module gda_ctrl import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  gda_stat_t stat,
    output gda_ctl_t  ctl
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ctl.cmd    = CMD_IDLE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.cmd    = CMD_CAPTURE;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
                if (stat.op == OP_NONE)
                begin
                    ctl.cmd    = CMD_RES_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.cmd    = CMD_LD_FIRST;
                    phase_next = PH_FIRST;
                    state_next = S_SER_A;
                end
            S_SER_A:
            begin
                ctl.cmd    = CMD_SER_A;
                state_next = S_SER_B;
            end
            S_SER_B:
            begin
                ctl.cmd    = CMD_SER_B;
                state_next = S_SER_C;
            end
            S_SER_C:
            begin
                ctl.cmd    = CMD_SER_C;
                state_next = S_CHECK;
            end
            S_CHECK:
                case (phase_reg)
                    PH_FIRST:
                        if (!stat.date_ok)
                        begin
                            ctl.cmd    = CMD_RES_BAD;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd    = CMD_SAVE_FIRST;
                            state_next = (stat.op == OP_BETWEEN || stat.op == OP_COMPARE)
                                         ? S_LOAD2 : S_TARGET;
                        end
                    PH_SECOND:
                    begin
                        if (!stat.date_ok)
                            ctl.cmd = CMD_RES_BAD;
                        else if (stat.op == OP_BETWEEN)
                            ctl.cmd = CMD_RES_DIFF;
                        else
                            ctl.cmd = CMD_RES_CMP;
                        state_next = S_DONE;
                    end
                    default:
                        if (!stat.year_ok)
                        begin
                            ctl.cmd    = CMD_RES_RANGE;
                            state_next = S_DONE;
                        end
                        else
                            state_next = S_CONV_CHK;
                endcase
            S_LOAD2:
            begin
                ctl.cmd    = CMD_LD_SECOND;
                phase_next = PH_SECOND;
                state_next = S_SER_A;
            end
            S_TARGET:
                case (stat.op)
                    OP_ADD_YEARS:
                    begin
                        ctl.cmd    = CMD_LD_YEARS;
                        phase_next = PH_TARGET;
                        state_next = S_SER_A;
                    end
                    OP_ADD_MONTHS:
                    begin
                        ctl.cmd    = CMD_MONTH_DIV;
                        state_next = S_LOAD_M;
                    end
                    default:
                        if (stat.op == OP_PREV && stat.first_zero)
                        begin
                            ctl.cmd    = CMD_RES_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ctl.cmd    = CMD_TARGET;
                            state_next = S_CONV_CHK;
                        end
                endcase
            S_LOAD_M:
            begin
                ctl.cmd    = CMD_LD_MONTHS;
                phase_next = PH_TARGET;
                state_next = S_SER_A;
            end
            S_CONV_CHK:
                if (stat.ser_over)
                begin
                    ctl.cmd    = CMD_RES_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.cmd    = CMD_CV_INIT;
                    state_next = S_CV_400;
                end
            S_CV_400:
            begin
                ctl.cmd = CMD_CV_400;
                if (!stat.cv_more)
                    state_next = S_CV_100;
            end
            S_CV_100:
            begin
                ctl.cmd = CMD_CV_100;
                if (!stat.cv_more)
                    state_next = S_CV_4;
            end
            S_CV_4:
            begin
                ctl.cmd = CMD_CV_4;
                if (!stat.cv_more)
                    state_next = S_CV_1;
            end
            S_CV_1:
            begin
                ctl.cmd = CMD_CV_1;
                if (!stat.cv_more)
                    state_next = S_CV_MONTH;
            end
            S_CV_MONTH:
            begin
                ctl.cmd = CMD_CV_MONTH;
                if (!stat.cv_more)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                ctl.cmd    = CMD_RES_DATE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* design/gregorian_date_arithmetic_core.sv */
// Gregorian date arithmetic core: one item in flight, one result per item.
// A date result waits on the back-conversion loop, which takes one 400/100/4/1-year block
// or one month per cycle.
// A new item is taken only after the result of the last one has been accepted.
// Reset (rst_n, async, active low) returns the controller to idle; no result pending.
module gregorian_date_arithmetic_core import gda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gda_req_if.sink   req,
    gda_rsp_if.source rsp
);

    gda_ctl_t  ctl;
    gda_stat_t stat;

    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    gda_datapath u_datapath (
        .clk          (clk),
        .ctl          (ctl),
        .stat         (stat),
        .operation    (req.operation),
        .first_year   (req.first_year),
        .first_month  (req.first_month),
        .first_day    (req.first_day),
        .amount       (req.amount),
        .second_year  (req.second_year),
        .second_month (req.second_month),
        .second_day   (req.second_day),
        .result_year  (rsp.result_year),
        .result_month (rsp.result_month),
        .result_day   (rsp.result_day),
        .day_count    (rsp.day_count),
        .is_less      (rsp.is_less),
        .is_equal     (rsp.is_equal),
        .status       (rsp.status)
    );

endmodule

/* design/gda_checker.sv */
// Port-level checks for the date core, bound to the top level.
// Depends on gda_pkg and gregorian_date_arithmetic_core.
module gda_checker import gda_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [YEAR_W-1:0]          result_year,
    input logic [MONTH_W-1:0]         result_month,
    input logic [DAY_W-1:0]           result_day,
    input logic signed [COUNT_W-1:0]  day_count,
    input logic                       is_less,
    input logic                       is_equal,
    input logic [STATUS_W-1:0]        status
);

    // one item at a time: no intake while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid)
        else $error("item taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
                                       && $stable(day_count)))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (result_year == '0 && result_month == '0
            && result_day == '0 && day_count == '0 && !is_less && !is_equal))
        else $error("error result carries data");

    a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_year != '0) |-> (result_month >= 4'd1
            && result_month <= 4'd12 && result_day >= 5'd1
            && result_year <= YEAR_MAX))
        else $error("malformed result date");

    a_cmp_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_less && is_equal))
        else $error("less and equal both set");

endmodule

bind gregorian_date_arithmetic_core gda_checker u_gda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .result_year  (rsp.result_year),
    .result_month (rsp.result_month),
    .result_day   (rsp.result_day),
    .day_count    (rsp.day_count),
    .is_less      (rsp.is_less),
    .is_equal     (rsp.is_equal),
    .status       (rsp.status)
);
